// ----- design/melody_note_sequencer_assert.svh -----
// ---------------------------------------------------------------------------
// Melody note sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MELODY_NOTE_SEQUENCER_ASSERT_SVH
`define MELODY_NOTE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define MNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mns_pkg.sv -----
// ---------------------------------------------------------------------------
// Melody note sequencer package
// Request and player codes, and the transaction and table entry types.
// ---------------------------------------------------------------------------
package mns_pkg;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_LOAD   = 3'd1;
    localparam logic [2:0] REQ_START  = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_RESUME = 3'd4;
    localparam logic [2:0] REQ_MUTE   = 3'd5;
    localparam logic [2:0] REQ_UNMUTE = 3'd6;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_ACTIVE  = 2'd1;
    localparam logic [1:0] MODE_PLAYING = 2'd2;
    localparam logic [1:0] MODE_PAUSED  = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [5:0]  note_index;
        logic [15:0] note_freq;
        logic [31:0] note_dur;
        logic [6:0]  note_count;
    } req_t;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic [1:0]  player_state;
        logic        is_muted;
        logic [6:0]  current_note;
    } rsp_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [31:0] dur;
    } note_entry_t;

endpackage

// ----- design/melody_note_sequencer.sv -----
// ---------------------------------------------------------------------------
// Melody note sequencer
// Plays a melody from a note table of frequencies and durations.
// ---------------------------------------------------------------------------
// One request transaction is taken in every cycle while req_stall is low; its
// response is registered in the output buffer, one response per request.
// The note table is a single-port-write memory with a registered read; the
// entry at the next note position is read at each clock edge, so a tick
// always sees the entry for the current note. A two-deep output buffer keeps
// requests flowing while a response waits; req_stall rises only when both
// entries are held. Table entries read before they are loaded are undefined.
// ---------------------------------------------------------------------------
module melody_note_sequencer #(
    parameter int MAX_NOTES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mns_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mns_pkg::rsp_t rsp
);

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    logic                 accept;
    logic                 buf_full;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    mns_pkg::note_entry_t wr_entry;
    mns_pkg::note_entry_t rd_entry;
    mns_pkg::rsp_t        result;

    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;

    mns_note_mem #(
        .DEPTH (MAX_NOTES),
        .AW    (AW)
    ) u_note_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    mns_ctrl #(
        .MAX_NOTES (MAX_NOTES),
        .AW        (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .rd_entry (rd_entry),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .result   (result)
    );

    mns_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .valid     (rsp_valid),
        .stall     (rsp_stall),
        .data      (rsp)
    );

`include "melody_note_sequencer_assert.svh"

    `MNS_ASSERT_NOW(a_stall_needs_rsp, req_stall, rsp_valid, "stall raised with no response held")
    `MNS_ASSERT_NEXT(a_accept_fills, accept && !rsp_valid, rsp_valid, "accepted request lost")
    `MNS_ASSERT_NOW(a_quiet_when_stopped, rsp_valid && ((rsp.player_state == mns_pkg::MODE_IDLE) || (rsp.player_state == mns_pkg::MODE_PAUSED)), rsp.tone_freq == 16'd0, "tone driven while idle or paused")

endmodule

// ----- design/mns_note_mem.sv -----
// ---------------------------------------------------------------------------
// Note table memory
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded to the read data.
// ---------------------------------------------------------------------------
module mns_note_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  mns_pkg::note_entry_t wr_entry,
    input  logic [AW-1:0]       rd_addr,
    output mns_pkg::note_entry_t rd_entry
);

    mns_pkg::note_entry_t mem [DEPTH];
    mns_pkg::note_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_entry_reg <= wr_entry;
        end
        else
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- design/mns_ctrl.sv -----
// ---------------------------------------------------------------------------
// Melody note sequencer control
// Player state machine and note position; applies one accepted request
// transaction per cycle and presents the resulting player status.
// ---------------------------------------------------------------------------
module mns_ctrl #(
    parameter int MAX_NOTES = 64,
    parameter int AW        = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  mns_pkg::req_t        req,
    input  mns_pkg::note_entry_t rd_entry,
    output logic [AW-1:0]        rd_addr,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output mns_pkg::note_entry_t wr_entry,
    output mns_pkg::rsp_t        result
);

    logic [1:0]  mode_reg,   mode_next;
    logic        loaded_reg, loaded_next;
    logic [6:0]  length_reg, length_next;
    logic [6:0]  pos_reg,    pos_next;
    logic [31:0] start_reg,  start_next;
    logic [15:0] freq_reg,   freq_next;
    logic        muted_reg,  muted_next;

    logic [31:0] elapsed;
    logic [6:0]  count_sat;
    logic        pos_done;

    assign elapsed   = req.now_ms - start_reg;
    assign count_sat = (32'(req.note_count) > 32'(MAX_NOTES)) ?
                       7'(MAX_NOTES) : req.note_count;
    assign pos_done  = (pos_reg >= length_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        loaded_next = loaded_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        freq_next   = freq_reg;
        muted_next  = muted_reg;
        wr_en       = 1'b0;
        if (accept)
        begin
            unique case (req.req_type)
                mns_pkg::REQ_TICK:
                begin
                    if (!muted_reg)
                    begin
                        unique case (mode_reg)
                            mns_pkg::MODE_IDLE:
                            begin
                                if (loaded_reg)
                                begin
                                    mode_next = mns_pkg::MODE_ACTIVE;
                                end
                            end
                            mns_pkg::MODE_ACTIVE:
                            begin
                                if (pos_done)
                                begin
                                    mode_next   = mns_pkg::MODE_IDLE;
                                    loaded_next = 1'b0;
                                    pos_next    = '0;
                                    freq_next   = '0;
                                end
                                else
                                begin
                                    freq_next  = rd_entry.freq;
                                    start_next = req.now_ms;
                                    mode_next  = mns_pkg::MODE_PLAYING;
                                end
                            end
                            mns_pkg::MODE_PLAYING:
                            begin
                                if (pos_done)
                                begin
                                    freq_next = '0;
                                    mode_next = mns_pkg::MODE_ACTIVE;
                                end
                                else if (elapsed >= rd_entry.dur)
                                begin
                                    freq_next = '0;
                                    mode_next = mns_pkg::MODE_ACTIVE;
                                    pos_next  = pos_reg + 7'd1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                mns_pkg::REQ_LOAD:
                begin
                    wr_en = (32'(req.note_index) < 32'(MAX_NOTES));
                end
                mns_pkg::REQ_START:
                begin
                    mode_next   = mns_pkg::MODE_IDLE;
                    loaded_next = 1'b1;
                    pos_next    = '0;
                    freq_next   = '0;
                    length_next = count_sat;
                end
                mns_pkg::REQ_PAUSE:
                begin
                    freq_next = '0;
                    mode_next = mns_pkg::MODE_PAUSED;
                end
                mns_pkg::REQ_RESUME:
                begin
                    mode_next = loaded_reg ? mns_pkg::MODE_PLAYING : mns_pkg::MODE_IDLE;
                end
                mns_pkg::REQ_MUTE:
                begin
                    muted_next = 1'b1;
                end
                mns_pkg::REQ_UNMUTE:
                begin
                    muted_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= mns_pkg::MODE_IDLE;
            loaded_reg <= 1'b0;
            length_reg <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            freq_reg   <= '0;
            muted_reg  <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            loaded_reg <= loaded_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            freq_reg   <= freq_next;
            muted_reg  <= muted_next;
        end
    end

    assign rd_addr       = AW'(32'(pos_next));
    assign wr_addr       = AW'(32'(req.note_index));
    assign wr_entry.freq = req.note_freq;
    assign wr_entry.dur  = req.note_dur;

    assign result.tone_freq    = freq_next;
    assign result.player_state = mode_next;
    assign result.is_muted     = muted_next;
    assign result.current_note = pos_next;

endmodule

// ----- design/mns_out_buf.sv -----
// ---------------------------------------------------------------------------
// Result output buffer
// Output register with a skid stage, so that a new request transaction is
// taken while a finished result is still waiting downstream.
// ---------------------------------------------------------------------------
module mns_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mns_pkg::rsp_t push_data,
    output logic          full,
    output logic          valid,
    input  logic          stall,
    output mns_pkg::rsp_t data
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    mns_pkg::rsp_t out_data_reg;
    mns_pkg::rsp_t skid_data_reg;
    logic          pop;

    assign pop = out_valid_reg && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_data_reg;

endmodule
